// ===== sv/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants for the positional list store: request kinds,
// status codes, default sizes and the shift control handed to each cell.
// ----------------------------------------------------------------------------
package pls_pkg;

   // default sizes
   localparam int CAPACITY_DEF   = 16;
   localparam int WORD_WIDTH_DEF = 32;

   // fixed port widths
   localparam int DATA_W = 32;
   localparam int POS_W  = 5;
   localparam int KIND_W = 3;
   localparam int STAT_W = 2;

   // request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_INS_FRONT = 3'd0,
      KIND_INS_BACK  = 3'd1,
      KIND_DEL_FRONT = 3'd2,
      KIND_DEL_BACK  = 3'd3,
      KIND_INS_AT    = 3'd4,
      KIND_DEL_AT    = 3'd5
   } kind_type;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_BADPOS = 2'd2,
      STAT_FULL   = 2'd3
   } status_type;

   // shift command broadcast along the row of cells
   typedef struct packed {
      logic insert;   // open a gap at the target index
      logic remove;   // close the gap left at the target index
   } shift_ctl_type;

endpackage

// ===== sv/pls_cell.sv =====
// ----------------------------------------------------------------------------
// pls_cell
// One slot of the list. Holds a word and an occupied flag; on an insert it
// takes the word from its left neighbour (or the new word at the target),
// on a delete it takes the word from its right neighbour.
// ----------------------------------------------------------------------------
module pls_cell #(
   parameter int WORD_WIDTH = pls_pkg::WORD_WIDTH_DEF,
   parameter int IDX_W      = 4,
   parameter int INDEX      = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pls_pkg::shift_ctl_type    ctl,
   input  logic [IDX_W-1:0]          idx,
   input  logic [WORD_WIDTH-1:0]     new_word,
   input  logic [WORD_WIDTH-1:0]     left_word,
   input  logic                      left_occ,
   input  logic [WORD_WIDTH-1:0]     right_word,
   input  logic                      right_occ,
   output logic [WORD_WIDTH-1:0]     word,
   output logic                      occ
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [WORD_WIDTH-1:0] word_ff, word_in;
   logic                  occ_ff, occ_in;

   // shift selection
   always_comb begin
      word_in = word_ff;
      occ_in  = occ_ff;
      if (ctl.insert) begin
         if (MY_IDX == idx) begin
            word_in = new_word;
            occ_in  = 1'b1;
         end else if (MY_IDX > idx) begin
            word_in = left_word;
            occ_in  = left_occ;
         end
      end else if (ctl.remove) begin
         if (MY_IDX >= idx) begin
            word_in = right_word;
            occ_in  = right_occ;
         end
      end
   end

   // occupied flag
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
   assign occ  = occ_ff;

endmodule

// ===== sv/positional_list_store.sv =====
// ----------------------------------------------------------------------------
// positional_list_store
// Bounded ordered list of signed words with insert and delete at the front,
// the back or any 1-based position, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// A request is taken on any clock edge with start high; busy never rises, so
// one request can follow another in every cycle. The row of cells shifts open
// or closed around the target in the cycle the request is taken, and the
// result (status, new count, removed word, first and last words) is shown
// with rsp_strobe high for the single following cycle, one request per
// cycle. The receiver must take the result in that cycle.
// Positions outside 1..count+1 (insert) or 1..count (delete) are rejected
// with a bad position status; an insert into a full store reports full.
// ----------------------------------------------------------------------------
module positional_list_store #(
   parameter int CAPACITY   = pls_pkg::CAPACITY_DEF,
   parameter int WORD_WIDTH = pls_pkg::WORD_WIDTH_DEF,
   localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [pls_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [pls_pkg::DATA_W-1:0]   req_value,
   input  logic [pls_pkg::POS_W-1:0]           req_position,
   output logic                                rsp_strobe,
   output logic [pls_pkg::STAT_W-1:0]          rsp_status,
   output logic [CNT_W-1:0]                    rsp_count,
   output logic signed [pls_pkg::DATA_W-1:0]   rsp_removed_value,
   output logic signed [pls_pkg::DATA_W-1:0]   rsp_first_value,
   output logic signed [pls_pkg::DATA_W-1:0]   rsp_last_value
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W = ((CNT_W > pls_pkg::POS_W) ? CNT_W : pls_pkg::POS_W) + 1;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // word to output: sign-extend or cut to the port width
   function automatic logic [pls_pkg::DATA_W-1:0] to_port(input logic [WORD_WIDTH-1:0] w);
      logic signed [WORD_WIDTH-1:0] s;
      s = w;
      return pls_pkg::DATA_W'(s);
   endfunction

   logic [WORD_WIDTH-1:0]  cell_word [CAPACITY];
   logic                   cell_occ  [CAPACITY];
   logic [WORD_WIDTH-1:0]  in_word;

   pls_pkg::shift_ctl_type ctl;
   logic [IDX_W-1:0]       idx;
   pls_pkg::status_type    status;
   logic [WORD_WIDTH-1:0]  taken_word;
   logic [WORD_WIDTH-1:0]  last_word;

   logic                   strobe_ff;
   pls_pkg::status_type    status_ff;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [WORD_WIDTH-1:0]  removed_ff, removed_in;

   logic [CMP_W-1:0]       pos_x, cnt_x;
   logic                   full, empty;

   assign in_word = WORD_WIDTH'(req_value);
   assign busy    = 1'b0;

   // request decode and range checks
   always_comb begin
      pos_x  = CMP_W'(req_position);
      cnt_x  = CMP_W'(count_ff);
      full   = (count_ff == CAP_CNT);
      empty  = (count_ff == '0);
      ctl    = '0;
      idx    = '0;
      status = pls_pkg::STAT_OK;
      unique case (pls_pkg::kind_type'(req_kind)) inside
         pls_pkg::KIND_INS_FRONT,
         pls_pkg::KIND_INS_BACK: begin
            if (full) begin
               status = pls_pkg::STAT_FULL;
            end else begin
               ctl.insert = 1'b1;
               idx = (req_kind == pls_pkg::KIND_INS_FRONT) ? '0 : IDX_W'(count_ff);
            end
         end
         pls_pkg::KIND_DEL_FRONT,
         pls_pkg::KIND_DEL_BACK: begin
            if (empty) begin
               status = pls_pkg::STAT_EMPTY;
            end else begin
               ctl.remove = 1'b1;
               idx = (req_kind == pls_pkg::KIND_DEL_FRONT) ? '0 : IDX_W'(count_ff - 1'b1);
            end
         end
         pls_pkg::KIND_INS_AT: begin
            if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
               status = pls_pkg::STAT_BADPOS;
            end else if (full) begin
               status = pls_pkg::STAT_FULL;
            end else begin
               ctl.insert = 1'b1;
               idx = IDX_W'(pos_x - 1'b1);
            end
         end
         pls_pkg::KIND_DEL_AT: begin
            if (pos_x == '0 || pos_x > cnt_x) begin
               status = pls_pkg::STAT_BADPOS;
            end else begin
               ctl.remove = 1'b1;
               idx = IDX_W'(pos_x - 1'b1);
            end
         end
         default: begin
            status = pls_pkg::STAT_BADPOS;
         end
      endcase
      if (!start) begin
         ctl = '0;
      end
   end

   // word leaving the list: masked OR over the cells
   always_comb begin
      taken_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (IDX_W'(i) == idx) begin
            taken_word = taken_word | cell_word[i];
         end
      end
   end

   // tail word: the occupied cell whose right neighbour is empty
   always_comb begin
      last_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_occ[i] && (i == CAPACITY - 1 || !cell_occ[(i + 1) % CAPACITY])) begin
            last_word = last_word | cell_word[i];
         end
      end
   end

   // count and removed word
   always_comb begin
      count_in   = count_ff;
      removed_in = '0;
      if (ctl.insert) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.remove) begin
         count_in   = count_ff - 1'b1;
         removed_in = taken_word;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         strobe_ff <= start;
         count_ff  <= count_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      status_ff  <= status;
      removed_ff <= removed_in;
   end

   // row of cells
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [WORD_WIDTH-1:0] lw, rw;
      logic                  lo, ro;
      if (g == 0) begin : g_head
         assign lw = '0;
         assign lo = 1'b0;
      end else begin : g_mid_l
         assign lw = cell_word[g-1];
         assign lo = cell_occ[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign rw = '0;
         assign ro = 1'b0;
      end else begin : g_mid_r
         assign rw = cell_word[g+1];
         assign ro = cell_occ[g+1];
      end
      pls_cell #(
         .WORD_WIDTH (WORD_WIDTH),
         .IDX_W      (IDX_W),
         .INDEX      (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .idx        (idx),
         .new_word   (in_word),
         .left_word  (lw),
         .left_occ   (lo),
         .right_word (rw),
         .right_occ  (ro),
         .word       (cell_word[g]),
         .occ        (cell_occ[g])
      );
   end

   // result ports
   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_count         = count_ff;
   assign rsp_removed_value = to_port(removed_ff);
   assign rsp_first_value   = cell_occ[0] ? to_port(cell_word[0]) : '0;
   assign rsp_last_value    = to_port(last_word);

endmodule
